// File: rtl/ghbl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ghbl_pkg
// Shared types and constants of the grid height bilinear lookup unit.
// ----------------------------------------------------------------------------
package ghbl_pkg;

	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned COORD_W     = 32;
	localparam int unsigned PER_UNIT_W  = 32;
	localparam int unsigned SIZE_W      = 10;
	localparam int unsigned IDX_FIELD_W = 9;
	localparam int unsigned SAMPLE_W    = 16;
	localparam int unsigned HEIGHT_W    = 32;
	localparam int unsigned FRAC_W      = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WEST_EDGE     = 3'd0,
		CFG_NORTH_EDGE    = 3'd1,
		CFG_COLS_PER_UNIT = 3'd2,
		CFG_ROWS_PER_UNIT = 3'd3,
		CFG_GRID_COLS     = 3'd4,
		CFG_GRID_ROWS     = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	localparam logic [COORD_W-1:0]    RST_WEST_EDGE  = 32'h0000_0000;
	localparam logic [COORD_W-1:0]    RST_NORTH_EDGE = 32'h0000_0000;
	localparam logic [PER_UNIT_W-1:0] RST_PER_UNIT   = 32'h0001_0000;
	localparam logic [SIZE_W-1:0]     RST_GRID_SIZE  = 10'd512;

	typedef struct packed {
		logic [IDX_FIELD_W-1:0] row;
		logic [IDX_FIELD_W-1:0] col;
		logic [SAMPLE_W-1:0]    sample;
	} wr_item_t;

endpackage : ghbl_pkg
`default_nettype wire

// File: rtl/ghbl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ghbl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ghbl_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                                       clk,
	input  wire logic                                       wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                           wr_data,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule : ghbl_ram
`default_nettype wire

// File: rtl/grid_height_bilinear_lookup_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_height_bilinear_lookup_unit
// Height grid with bilinear point lookup, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One transaction is taken on every clock in which start is high; busy never
// rises. A query's height leaves on done/height from the output register,
// in order, one result per clock at most. A sample write lands in the grid
// from the stage s6 registers, in step with the query read port, so any
// later query sees it. The grid is split by row and column parity into four
// RAM banks, each giving one corner per clock, which sets the rate of one
// transaction per clock. The grid is not cleared at reset: query only cells
// that were written. Coordinate offsets are multiplied in two 33x16 halves.
// ----------------------------------------------------------------------------
module grid_height_bilinear_lookup_unit
	import ghbl_pkg::*;
#(
	parameter int unsigned MAX_ROWS = 512,
	parameter int unsigned MAX_COLS = 512
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          kind,
	input  wire logic [IDX_FIELD_W-1:0]        row_index,
	input  wire logic [IDX_FIELD_W-1:0]        col_index,
	input  wire logic signed [SAMPLE_W-1:0]    sample,
	input  wire logic signed [COORD_W-1:0]     lon_coord,
	input  wire logic signed [COORD_W-1:0]     lat_coord,
	input  wire logic                          cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_wdata,
	output logic                               done,
	output logic signed [HEIGHT_W-1:0]         height
);

	localparam int unsigned RW    = $clog2(MAX_ROWS);
	localparam int unsigned CW    = $clog2(MAX_COLS);
	localparam int unsigned RHW   = (RW > 1) ? RW - 1 : 1;
	localparam int unsigned CHW   = (CW > 1) ? CW - 1 : 1;
	localparam int unsigned AW    = RHW + CHW;
	localparam int unsigned BDEPTH = 2 ** AW;

	// configuration
	logic [COORD_W-1:0]    west_edge_q;
	logic [COORD_W-1:0]    north_edge_q;
	logic [PER_UNIT_W-1:0] cols_pu_q;
	logic [PER_UNIT_W-1:0] rows_pu_q;
	logic [SIZE_W-1:0]     grid_cols_q;
	logic [SIZE_W-1:0]     grid_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			west_edge_q  <= RST_WEST_EDGE;
			north_edge_q <= RST_NORTH_EDGE;
			cols_pu_q    <= RST_PER_UNIT;
			rows_pu_q    <= RST_PER_UNIT;
			grid_cols_q  <= RST_GRID_SIZE;
			grid_rows_q  <= RST_GRID_SIZE;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WEST_EDGE:     west_edge_q  <= cfg_wdata;
				CFG_NORTH_EDGE:    north_edge_q <= cfg_wdata;
				CFG_COLS_PER_UNIT: cols_pu_q    <= cfg_wdata;
				CFG_ROWS_PER_UNIT: rows_pu_q    <= cfg_wdata;
				CFG_GRID_COLS:     grid_cols_q  <= cfg_wdata[SIZE_W-1:0];
				CFG_GRID_ROWS:     grid_rows_q  <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// last valid index of the grid in use
	logic [CW-1:0] ncols_m1;
	logic [RW-1:0] nrows_m1;

	always_comb begin
		if (grid_cols_q == '0) begin
			ncols_m1 = '0;
		end else if (32'(grid_cols_q) > MAX_COLS) begin
			ncols_m1 = CW'(MAX_COLS - 1);
		end else begin
			ncols_m1 = CW'(grid_cols_q - SIZE_W'(1));
		end
		if (grid_rows_q == '0) begin
			nrows_m1 = '0;
		end else if (32'(grid_rows_q) > MAX_ROWS) begin
			nrows_m1 = RW'(MAX_ROWS - 1);
		end else begin
			nrows_m1 = RW'(grid_rows_q - SIZE_W'(1));
		end
	end

	function automatic logic [29:0] clamp_hi(input logic [29:0] v, input logic [29:0] lim);
		return (v > lim) ? lim : v;
	endfunction

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ---------------- stage registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic q_s7, q_s8, q_s9, q_s10, done_q;

	logic kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6;
	wr_item_t wr_s1, wr_s2, wr_s3, wr_s4, wr_s5, wr_s6;

	logic [COORD_W-1:0] lon_s1, lat_s1;
	logic signed [32:0] dx_s2, dy_s2;
	logic [32:0] mag_x_s3, mag_y_s3;
	logic neg_x_s3, neg_y_s3, neg_x_s4, neg_y_s4, neg_x_s5, neg_y_s5;
	logic [48:0] pl_x_s4, ph_x_s4, pl_y_s4, ph_y_s4;
	logic [64:0] prod_x_s5, prod_y_s5;
	logic [CW-1:0] c0_s6, c1_s6;
	logic [RW-1:0] r0_s6, r1_s6;
	logic [FRAC_W-1:0] fx_s6, fy_s6;
	logic [32:0] w_s7 [4];
	logic [1:0]  sel_s7 [4];
	logic signed [49:0] p_s8 [4];
	logic signed [49:0] sa_s9, sb_s9, tot_s10;
	logic [HEIGHT_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			q_s7   <= 1'b0;
			q_s8   <= 1'b0;
			q_s9   <= 1'b0;
			q_s10  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			q_s7   <= v_s6 && (kind_s6 == KIND_QUERY);
			q_s8   <= q_s7;
			q_s9   <= q_s8;
			q_s10  <= q_s9;
			done_q <= q_s10;
		end
	end

	// ---------------- offset, magnitude and multiply stages
	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		wr_s1   <= '{row: row_index, col: col_index, sample: sample};
		lon_s1  <= lon_coord;
		lat_s1  <= lat_coord;

		kind_s2 <= kind_s1;
		wr_s2   <= wr_s1;
		dx_s2   <= $signed({lon_s1[31], lon_s1}) - $signed({west_edge_q[31], west_edge_q});
		dy_s2   <= $signed({north_edge_q[31], north_edge_q}) - $signed({lat_s1[31], lat_s1});

		kind_s3  <= kind_s2;
		wr_s3    <= wr_s2;
		neg_x_s3 <= dx_s2[32];
		neg_y_s3 <= dy_s2[32];
		mag_x_s3 <= dx_s2[32] ? (~dx_s2 + 33'd1) : dx_s2;
		mag_y_s3 <= dy_s2[32] ? (~dy_s2 + 33'd1) : dy_s2;

		kind_s4  <= kind_s3;
		wr_s4    <= wr_s3;
		neg_x_s4 <= neg_x_s3;
		neg_y_s4 <= neg_y_s3;
		pl_x_s4  <= mag_x_s3 * cols_pu_q[15:0];
		ph_x_s4  <= mag_x_s3 * cols_pu_q[31:16];
		pl_y_s4  <= mag_y_s3 * rows_pu_q[15:0];
		ph_y_s4  <= mag_y_s3 * rows_pu_q[31:16];

		kind_s5   <= kind_s4;
		wr_s5     <= wr_s4;
		neg_x_s5  <= neg_x_s4;
		neg_y_s5  <= neg_y_s4;
		prod_x_s5 <= 65'(pl_x_s4) + {ph_x_s4, 16'b0};
		prod_y_s5 <= 65'(pl_y_s4) + {ph_y_s4, 16'b0};
	end

	// ---------------- floor/ceil, clamp, fractions
	logic [28:0] ipx, ipy;
	logic [35:0] fmx, fmy, fmx_n;
	logic        nzx, nzy;

	assign ipx   = prod_x_s5[64:36];
	assign ipy   = prod_y_s5[64:36];
	assign fmx   = prod_x_s5[35:0];
	assign fmy   = prod_y_s5[35:0];
	assign fmx_n = ~fmx + 36'd1;
	assign nzx   = |fmx;
	assign nzy   = |fmy;

	// a negative offset clamps both corner indices to zero
	always_ff @(posedge clk) begin
		kind_s6 <= kind_s5;
		wr_s6   <= wr_s5;
		c0_s6   <= neg_x_s5 ? '0 : CW'(clamp_hi({1'b0, ipx}, 30'(ncols_m1)));
		c1_s6   <= neg_x_s5 ? '0 : CW'(clamp_hi({1'b0, ipx} + 30'(nzx), 30'(ncols_m1)));
		r0_s6   <= neg_y_s5 ? '0 : RW'(clamp_hi({1'b0, ipy}, 30'(nrows_m1)));
		r1_s6   <= neg_y_s5 ? '0 : RW'(clamp_hi({1'b0, ipy} + 30'(nzy), 30'(nrows_m1)));
		fx_s6   <= neg_x_s5 ? fmx_n[35:20] : fmx[35:20];
		fy_s6   <= fmy[35:20];
	end

	// ---------------- grid banks: write port and four corner reads
	logic [RW-1:0] wrow;
	logic [CW-1:0] wcol;
	logic          wr_ok;
	logic [SAMPLE_W-1:0] rdata [4];

	assign wrow  = RW'(wr_s6.row);
	assign wcol  = CW'(wr_s6.col);
	assign wr_ok = v_s6 && (kind_s6 == KIND_WRITE)
		&& (32'(wr_s6.row) < MAX_ROWS) && (32'(wr_s6.col) < MAX_COLS);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam int unsigned RP = b / 2;
		localparam int unsigned CP = b % 2;

		logic [RW-1:0] rd_row;
		logic [CW-1:0] rd_col;
		logic          bank_we;

		assign rd_row  = (r0_s6[0] == 1'(RP)) ? r0_s6 : r1_s6;
		assign rd_col  = (c0_s6[0] == 1'(CP)) ? c0_s6 : c1_s6;
		assign bank_we = wr_ok && (wr_s6.row[0] == 1'(RP)) && (wr_s6.col[0] == 1'(CP));

		ghbl_ram #(
			.WIDTH (SAMPLE_W),
			.DEPTH (BDEPTH)
		) u_bank (
			.clk     (clk),
			.wr_en   (bank_we),
			.wr_addr ({RHW'(wrow >> 1), CHW'(wcol >> 1)}),
			.wr_data (wr_s6.sample),
			.rd_addr ({RHW'(rd_row >> 1), CHW'(rd_col >> 1)}),
			.rd_data (rdata[b])
		);
	end

	// ---------------- corner weights
	logic [16:0] wx0, wx1, wy0, wy1;

	assign wx1 = {1'b0, fx_s6};
	assign wx0 = 17'h1_0000 - wx1;
	assign wy1 = {1'b0, fy_s6};
	assign wy0 = 17'h1_0000 - wy1;

	// corners: top left, top right, bottom right, bottom left
	always_ff @(posedge clk) begin
		w_s7[0]   <= 33'(34'(wx0) * 34'(wy0));
		w_s7[1]   <= 33'(34'(wx1) * 34'(wy0));
		w_s7[2]   <= 33'(34'(wx1) * 34'(wy1));
		w_s7[3]   <= 33'(34'(wx0) * 34'(wy1));
		sel_s7[0] <= {r0_s6[0], c0_s6[0]};
		sel_s7[1] <= {r0_s6[0], c1_s6[0]};
		sel_s7[2] <= {r1_s6[0], c1_s6[0]};
		sel_s7[3] <= {r1_s6[0], c0_s6[0]};
	end

	// ---------------- blend, sum, round, saturate
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			p_s8[k] <= $signed(rdata[sel_s7[k]]) * $signed({1'b0, w_s7[k]});
		end
		sa_s9   <= p_s8[0] + p_s8[1];
		sb_s9   <= p_s8[2] + p_s8[3];
		tot_s10 <= sa_s9 + sb_s9;
	end

	logic signed [49:0] rnd;
	logic signed [33:0] shr;

	assign rnd = tot_s10 + 50'sd32768;
	assign shr = rnd[49:16];

	always_ff @(posedge clk) begin
		if (shr[33:31] == 3'b000 || shr[33:31] == 3'b111) begin
			height_q <= shr[31:0];
		end else begin
			height_q <= shr[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
	end

	assign done   = done_q;
	assign height = height_q;

endmodule : grid_height_bilinear_lookup_unit
`default_nettype wire
